@@ hdl/qvr_pkg.sv @@
// Package with widths, constants, payload types and arithmetic helpers of the rotator.
`default_nettype none

package qvr_pkg;

  localparam int unsigned DATA_W  = 16;              // quaternion, vector and result fields
  localparam int unsigned PROD_W  = 32;              // pairwise quaternion product
  localparam int unsigned TERM_W  = 33;              // matrix term before the factor two
  localparam int unsigned MUL_W   = 49;              // vector component times matrix term
  localparam int unsigned SUM_W   = 52;              // row sum with rounding bias
  localparam int unsigned FRAC_SH = 27;              // result scale is 2^27
  localparam int unsigned RND_W   = SUM_W - FRAC_SH; // rounded row sum

  localparam logic signed [TERM_W-1:0] HALF_Q28   = TERM_W'(134217728);
  localparam logic signed [SUM_W-1:0]  ROUND_BIAS = SUM_W'(67108864);
  localparam logic signed [RND_W-1:0]  RND_MAX    = RND_W'(32767);
  localparam logic signed [RND_W-1:0]  RND_MIN    = RND_W'(-32768);
  localparam logic signed [DATA_W-1:0] OUT_MAX    = DATA_W'(32767);
  localparam logic signed [DATA_W-1:0] OUT_MIN    = DATA_W'(-32768);

  typedef struct packed {
    logic                     mode;
    logic signed [DATA_W-1:0] quat_w;
    logic signed [DATA_W-1:0] quat_x;
    logic signed [DATA_W-1:0] quat_y;
    logic signed [DATA_W-1:0] quat_z;
    logic signed [DATA_W-1:0] vec_x;
    logic signed [DATA_W-1:0] vec_y;
    logic signed [DATA_W-1:0] vec_z;
  } qvr_in_t;

  typedef struct packed {
    logic                     mode;
    logic signed [PROD_W-1:0] wx;
    logic signed [PROD_W-1:0] wy;
    logic signed [PROD_W-1:0] wz;
    logic signed [PROD_W-1:0] xx;
    logic signed [PROD_W-1:0] xy;
    logic signed [PROD_W-1:0] xz;
    logic signed [PROD_W-1:0] yy;
    logic signed [PROD_W-1:0] yz;
    logic signed [PROD_W-1:0] zz;
    logic signed [DATA_W-1:0] vec_x;
    logic signed [DATA_W-1:0] vec_y;
    logic signed [DATA_W-1:0] vec_z;
  } qvr_prod_t;

  typedef struct packed {
    logic signed [TERM_W-1:0] m00;
    logic signed [TERM_W-1:0] m01;
    logic signed [TERM_W-1:0] m02;
    logic signed [TERM_W-1:0] m10;
    logic signed [TERM_W-1:0] m11;
    logic signed [TERM_W-1:0] m12;
    logic signed [TERM_W-1:0] m20;
    logic signed [TERM_W-1:0] m21;
    logic signed [TERM_W-1:0] m22;
    logic signed [DATA_W-1:0] vec_x;
    logic signed [DATA_W-1:0] vec_y;
    logic signed [DATA_W-1:0] vec_z;
  } qvr_term_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sx;
    logic signed [SUM_W-1:0] sy;
    logic signed [SUM_W-1:0] sz;
  } qvr_sum_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_x;
    logic signed [DATA_W-1:0] out_y;
    logic signed [DATA_W-1:0] out_z;
    logic                     saturated;
  } qvr_out_t;

  function automatic logic signed [PROD_W-1:0] mul_qq(logic signed [DATA_W-1:0] a,
                                                      logic signed [DATA_W-1:0] b);
    logic signed [PROD_W-1:0] ae;
    logic signed [PROD_W-1:0] be;
    ae = PROD_W'(a);
    be = PROD_W'(b);
    return ae * be;
  endfunction

  function automatic logic signed [TERM_W-1:0] ext_p(logic signed [PROD_W-1:0] p);
    return TERM_W'(p);
  endfunction

  function automatic logic signed [MUL_W-1:0] mul_vt(logic signed [DATA_W-1:0] v,
                                                     logic signed [TERM_W-1:0] t);
    logic signed [MUL_W-1:0] ve;
    logic signed [MUL_W-1:0] te;
    ve = MUL_W'(v);
    te = MUL_W'(t);
    return ve * te;
  endfunction

  function automatic logic signed [SUM_W-1:0] ext_m(logic signed [MUL_W-1:0] m);
    return SUM_W'(m);
  endfunction

endpackage

`default_nettype wire

@@ hdl/qvr_if.sv @@
// Valid/ready channel interfaces for the rotator's input and result streams.
`default_nettype none

interface qvr_in_if;
  import qvr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic signed [DATA_W-1:0] quat_w;
  logic signed [DATA_W-1:0] quat_x;
  logic signed [DATA_W-1:0] quat_y;
  logic signed [DATA_W-1:0] quat_z;
  logic signed [DATA_W-1:0] vec_x;
  logic signed [DATA_W-1:0] vec_y;
  logic signed [DATA_W-1:0] vec_z;

  modport source (
    output valid, mode, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
    input  ready
  );
  modport sink (
    input  valid, mode, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
    output ready
  );
endinterface

interface qvr_out_if;
  import qvr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] out_x;
  logic signed [DATA_W-1:0] out_y;
  logic signed [DATA_W-1:0] out_z;
  logic                     saturated;

  modport source (
    output valid, out_x, out_y, out_z, saturated,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, saturated,
    output ready
  );
endinterface

`default_nettype wire

@@ hdl/qvr_prod.sv @@
// First stage: the nine pairwise products of the quaternion components.
`default_nettype none

module qvr_prod (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire qvr_pkg::qvr_in_t  data_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output qvr_pkg::qvr_prod_t     data_o
);
  import qvr_pkg::*;

  logic      valid_q;
  qvr_prod_t data_d;
  qvr_prod_t data_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d.mode  = data_i.mode;
    data_d.wx    = mul_qq(data_i.quat_w, data_i.quat_x);
    data_d.wy    = mul_qq(data_i.quat_w, data_i.quat_y);
    data_d.wz    = mul_qq(data_i.quat_w, data_i.quat_z);
    data_d.xx    = mul_qq(data_i.quat_x, data_i.quat_x);
    data_d.xy    = mul_qq(data_i.quat_x, data_i.quat_y);
    data_d.xz    = mul_qq(data_i.quat_x, data_i.quat_z);
    data_d.yy    = mul_qq(data_i.quat_y, data_i.quat_y);
    data_d.yz    = mul_qq(data_i.quat_y, data_i.quat_z);
    data_d.zz    = mul_qq(data_i.quat_z, data_i.quat_z);
    data_d.vec_x = data_i.vec_x;
    data_d.vec_y = data_i.vec_y;
    data_d.vec_z = data_i.vec_z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

@@ hdl/qvr_matrix.sv @@
// Second stage: the nine rotation matrix terms, transposed for the conjugate.
`default_nettype none

module qvr_matrix (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  wire qvr_pkg::qvr_prod_t data_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output qvr_pkg::qvr_term_t      data_o
);
  import qvr_pkg::*;

  logic                     valid_q;
  qvr_term_t                data_d;
  qvr_term_t                data_q;
  logic signed [TERM_W-1:0] wx;
  logic signed [TERM_W-1:0] wy;
  logic signed [TERM_W-1:0] wz;

  assign ready_o = !valid_q || ready_i;

  // The conjugate flips the sign of the products that involve the scalar part.
  always_comb begin
    wx = data_i.mode ? -ext_p(data_i.wx) : ext_p(data_i.wx);
    wy = data_i.mode ? -ext_p(data_i.wy) : ext_p(data_i.wy);
    wz = data_i.mode ? -ext_p(data_i.wz) : ext_p(data_i.wz);

    data_d.m00   = HALF_Q28 - ext_p(data_i.yy) - ext_p(data_i.zz);
    data_d.m01   = ext_p(data_i.xy) - wz;
    data_d.m02   = wy + ext_p(data_i.xz);
    data_d.m10   = wz + ext_p(data_i.xy);
    data_d.m11   = HALF_Q28 - ext_p(data_i.xx) - ext_p(data_i.zz);
    data_d.m12   = ext_p(data_i.yz) - wx;
    data_d.m20   = ext_p(data_i.xz) - wy;
    data_d.m21   = wx + ext_p(data_i.yz);
    data_d.m22   = HALF_Q28 - ext_p(data_i.yy) - ext_p(data_i.xx);
    data_d.vec_x = data_i.vec_x;
    data_d.vec_y = data_i.vec_y;
    data_d.vec_z = data_i.vec_z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

@@ hdl/qvr_mac.sv @@
// Third and fourth stages: vector times matrix products, then the biased row sums.
`default_nettype none

module qvr_mac (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  wire qvr_pkg::qvr_term_t data_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output qvr_pkg::qvr_sum_t       data_o
);
  import qvr_pkg::*;

  logic                    mul_valid_q;
  logic                    mul_ready;
  logic signed [MUL_W-1:0] mul_d [9];
  logic signed [MUL_W-1:0] mul_q [9];
  logic                    sum_valid_q;
  qvr_sum_t                sum_d;
  qvr_sum_t                sum_q;

  assign mul_ready = !sum_valid_q || ready_i;
  assign ready_o   = !mul_valid_q || mul_ready;

  always_comb begin
    mul_d[0] = mul_vt(data_i.vec_x, data_i.m00);
    mul_d[1] = mul_vt(data_i.vec_y, data_i.m01);
    mul_d[2] = mul_vt(data_i.vec_z, data_i.m02);
    mul_d[3] = mul_vt(data_i.vec_x, data_i.m10);
    mul_d[4] = mul_vt(data_i.vec_y, data_i.m11);
    mul_d[5] = mul_vt(data_i.vec_z, data_i.m12);
    mul_d[6] = mul_vt(data_i.vec_x, data_i.m20);
    mul_d[7] = mul_vt(data_i.vec_y, data_i.m21);
    mul_d[8] = mul_vt(data_i.vec_z, data_i.m22);
  end

  // The rounding bias is folded into the sum so the last stage only shifts.
  always_comb begin
    sum_d.sx = ext_m(mul_q[0]) + ext_m(mul_q[1]) + ext_m(mul_q[2]) + ROUND_BIAS;
    sum_d.sy = ext_m(mul_q[3]) + ext_m(mul_q[4]) + ext_m(mul_q[5]) + ROUND_BIAS;
    sum_d.sz = ext_m(mul_q[6]) + ext_m(mul_q[7]) + ext_m(mul_q[8]) + ROUND_BIAS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      sum_valid_q <= 1'b0;
    end else begin
      if (ready_o) begin
        mul_valid_q <= valid_i;
      end
      if (mul_ready) begin
        sum_valid_q <= mul_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      mul_q <= mul_d;
    end
    if (mul_valid_q && mul_ready) begin
      sum_q <= sum_d;
    end
  end

  assign valid_o = sum_valid_q;
  assign data_o  = sum_q;

endmodule

`default_nettype wire

@@ hdl/qvr_round.sv @@
// Fifth stage: scale down, round and saturate each row into the output register.
`default_nettype none

module qvr_round (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire qvr_pkg::qvr_sum_t data_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output qvr_pkg::qvr_out_t      data_o
);
  import qvr_pkg::*;

  logic     valid_q;
  qvr_out_t data_d;
  qvr_out_t data_q;
  logic     sat_x;
  logic     sat_y;
  logic     sat_z;

  // The sum already carries the half-step bias, so an arithmetic shift gives
  // round to nearest with ties toward plus infinity.
  function automatic logic [DATA_W:0] round_sat(logic signed [SUM_W-1:0] s);
    logic signed [RND_W-1:0] r;
    r = RND_W'(s >>> FRAC_SH);
    if (r > RND_MAX) begin
      return {1'b1, OUT_MAX};
    end else if (r < RND_MIN) begin
      return {1'b1, OUT_MIN};
    end
    return {1'b0, r[DATA_W-1:0]};
  endfunction

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    {sat_x, data_d.out_x} = round_sat(data_i.sx);
    {sat_y, data_d.out_y} = round_sat(data_i.sy);
    {sat_z, data_d.out_z} = round_sat(data_i.sz);
    data_d.saturated      = sat_x || sat_y || sat_z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

@@ hdl/quaternion_vector_rotate_top.sv @@
// An input transfer moves through five register stages (products, matrix terms, vector
// multiplies, row sums, round and saturate), each holding one item, to the result.
// The pipeline takes one item per cycle while the output does not stall.
// A stage takes a new item whenever it is empty or its successor takes its item.
// Reset clears only the stage valid bits; payload registers are not reset.
`default_nettype none

module quaternion_vector_rotate_top (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  qvr_in_if.sink      in_i,
  qvr_out_if.source   out_o
);
  import qvr_pkg::*;

  qvr_in_t   in_data;
  logic      prod_valid;
  logic      prod_ready;
  qvr_prod_t prod_data;
  logic      term_valid;
  logic      term_ready;
  qvr_term_t term_data;
  logic      sum_valid;
  logic      sum_ready;
  qvr_sum_t  sum_data;
  qvr_out_t  out_data;

  always_comb begin
    in_data.mode   = in_i.mode;
    in_data.quat_w = in_i.quat_w;
    in_data.quat_x = in_i.quat_x;
    in_data.quat_y = in_i.quat_y;
    in_data.quat_z = in_i.quat_z;
    in_data.vec_x  = in_i.vec_x;
    in_data.vec_y  = in_i.vec_y;
    in_data.vec_z  = in_i.vec_z;
  end

  qvr_prod u_prod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .data_i  (in_data),
    .valid_o (prod_valid),
    .ready_i (prod_ready),
    .data_o  (prod_data)
  );

  qvr_matrix u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prod_valid),
    .ready_o (prod_ready),
    .data_i  (prod_data),
    .valid_o (term_valid),
    .ready_i (term_ready),
    .data_o  (term_data)
  );

  qvr_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (term_valid),
    .ready_o (term_ready),
    .data_i  (term_data),
    .valid_o (sum_valid),
    .ready_i (sum_ready),
    .data_o  (sum_data)
  );

  qvr_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sum_valid),
    .ready_o (sum_ready),
    .data_i  (sum_data),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (out_data)
  );

  assign out_o.out_x     = out_data.out_x;
  assign out_o.out_y     = out_data.out_y;
  assign out_o.out_z     = out_data.out_z;
  assign out_o.saturated = out_data.saturated;

endmodule

`default_nettype wire

@@ hdl/qvr_checker.sv @@
// Port-level checks on the rotator's handshakes, latency and saturation flag.
`default_nettype none

module qvr_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_ready_i,
  input wire logic                      out_valid_i,
  input wire logic                      out_ready_i,
  input wire logic signed [15:0]        out_x_i,
  input wire logic signed [15:0]        out_y_i,
  input wire logic signed [15:0]        out_z_i,
  input wire logic                      saturated_i
);
  import qvr_pkg::*;

  // A stalled result stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_x_i) && $stable(out_y_i)
      && $stable(out_z_i) && $stable(saturated_i))
    else $error("result changed or dropped while stalled");

  // With the output taking results, every stage can move, so the input is open.
  a_in_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input stalled although the output takes results");

  // An accepted item reaches the output while the output keeps taking results.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i
      ##1 out_ready_i |=> out_valid_i)
    else $error("result missing after the pipeline latency");

  // A clipped result has at least one component at a range limit.
  a_sat_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && saturated_i |-> out_x_i == OUT_MAX || out_x_i == OUT_MIN
      || out_y_i == OUT_MAX || out_y_i == OUT_MIN
      || out_z_i == OUT_MAX || out_z_i == OUT_MIN)
    else $error("saturation flag without a clipped component");

endmodule

bind quaternion_vector_rotate_top qvr_checker u_qvr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_x_i     (out_o.out_x),
  .out_y_i     (out_o.out_y),
  .out_z_i     (out_o.out_z),
  .saturated_i (out_o.saturated)
);

`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for the quaternion vector rotator: directed, random and stall tests.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import qvr_pkg::*;

  localparam logic MODE_ROTATE  = 1'b0;
  localparam logic MODE_INVERSE = 1'b1;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  qvr_in_if  in_ch ();
  qvr_out_if out_ch ();

  quaternion_vector_rotate_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  qvr_out_t    expected_rotations [$];
  int unsigned mismatch_count    = 0;
  bit          sender_idle       = 1'b1;
  bit          receiver_idle     = 1'b1;
  int unsigned sink_hold_cycles  = 0;

  // Predicted rotation of one vector: exact row sums at scale 2^27, one rounding, saturation.
  function automatic qvr_out_t rotate_vector(qvr_in_t item);
    longint w, x, y, z, vx, vy, vz;
    longint pwx, pwy, pwz, pxx, pxy, pxz, pyy, pyz, pzz;
    longint unit_half;
    longint row_sum [3];
    longint rounded;
    logic signed [DATA_W-1:0] comp [3];
    qvr_out_t res;
    w  = longint'($signed(item.quat_w));
    x  = longint'($signed(item.quat_x));
    y  = longint'($signed(item.quat_y));
    z  = longint'($signed(item.quat_z));
    vx = longint'($signed(item.vec_x));
    vy = longint'($signed(item.vec_y));
    vz = longint'($signed(item.vec_z));
    pwx = w * x;  pwy = w * y;  pwz = w * z;
    pxx = x * x;  pxy = x * y;  pxz = x * z;
    pyy = y * y;  pyz = y * z;  pzz = z * z;
    // The conjugate rotation is the transposed matrix, i.e. the w products change sign.
    if (item.mode == MODE_INVERSE) begin
      pwx = -pwx;
      pwy = -pwy;
      pwz = -pwz;
    end
    unit_half = longint'(1) <<< 27;
    row_sum[0] = vx * (unit_half - pyy - pzz) + vy * (pxy - pwz) + vz * (pwy + pxz);
    row_sum[1] = vx * (pwz + pxy) + vy * (unit_half - pxx - pzz) + vz * (pyz - pwx);
    row_sum[2] = vx * (pxz - pwy) + vy * (pwx + pyz) + vz * (unit_half - pyy - pxx);
    res.saturated = 1'b0;
    for (int k = 0; k < 3; k++) begin
      rounded = (row_sum[k] + (longint'(1) <<< 26)) >>> 27;
      if (rounded > 32767) begin
        rounded = 32767;
        res.saturated = 1'b1;
      end
      if (rounded < -32768) begin
        rounded = -32768;
        res.saturated = 1'b1;
      end
      comp[k] = DATA_W'(rounded);
    end
    res.out_x = comp[0];
    res.out_y = comp[1];
    res.out_z = comp[2];
    return res;
  endfunction

  function automatic qvr_in_t make_item(logic m, int w, int x, int y, int z,
                                        int vx, int vy, int vz);
    qvr_in_t item;
    item.mode   = m;
    item.quat_w = DATA_W'(w);
    item.quat_x = DATA_W'(x);
    item.quat_y = DATA_W'(y);
    item.quat_z = DATA_W'(z);
    item.vec_x  = DATA_W'(vx);
    item.vec_y  = DATA_W'(vy);
    item.vec_z  = DATA_W'(vz);
    return item;
  endfunction

  function automatic logic signed [DATA_W-1:0] random_word();
    return DATA_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic signed [DATA_W-1:0] corner_word();
    int unsigned sel;
    sel = $urandom_range(0, 5);
    case (sel)
      0: return DATA_W'(-32768);
      1: return DATA_W'(-1);
      2: return DATA_W'(0);
      3: return DATA_W'(1);
      4: return DATA_W'(16384);
      default: return DATA_W'(32767);
    endcase
  endfunction

  // Mostly unit quaternions with random axes; the rest is raw noise, corners, or
  // quaternions a little off unit length.
  function automatic qvr_in_t random_rotation();
    real c [4];
    real norm;
    int unsigned kind;
    logic signed [DATA_W-1:0] q [4];
    qvr_in_t item;
    kind = $urandom_range(0, 9);
    item = make_item(1'($urandom_range(0, 1)), 0, 0, 0, 0, 0, 0, 0);
    if (kind <= 5 || kind == 8) begin
      norm = 0.0;
      for (int k = 0; k < 4; k++) begin
        c[k] = ($itor($urandom_range(0, 65535)) - 32768.0) / 32768.0;
        norm = norm + c[k] * c[k];
      end
      if (norm < 1.0e-4) begin
        c[0] = 1.0;
        norm = 1.0;
      end
      norm = $sqrt(norm);
      for (int k = 0; k < 4; k++) begin
        c[k] = c[k] / norm * 16384.0;
        if (kind == 8) begin
          c[k] = c[k] * (0.9 + 0.2 * $itor($urandom_range(0, 1000)) / 1000.0);
        end
        q[k] = DATA_W'($rtoi(c[k] >= 0.0 ? c[k] + 0.5 : c[k] - 0.5));
      end
      item.quat_w = q[0];
      item.quat_x = q[1];
      item.quat_y = q[2];
      item.quat_z = q[3];
      if ($urandom_range(0, 1) == 0) begin
        item.vec_x = random_word();
        item.vec_y = random_word();
        item.vec_z = random_word();
      end else begin
        item.vec_x = DATA_W'(int'($urandom_range(0, 2000)) - 1000);
        item.vec_y = DATA_W'(int'($urandom_range(0, 2000)) - 1000);
        item.vec_z = DATA_W'(int'($urandom_range(0, 2000)) - 1000);
      end
    end else if (kind == 9) begin
      item.quat_w = corner_word();
      item.quat_x = corner_word();
      item.quat_y = corner_word();
      item.quat_z = corner_word();
      item.vec_x  = corner_word();
      item.vec_y  = corner_word();
      item.vec_z  = corner_word();
    end else begin
      item.quat_w = random_word();
      item.quat_x = random_word();
      item.quat_y = random_word();
      item.quat_z = random_word();
      item.vec_x  = random_word();
      item.vec_y  = random_word();
      item.vec_z  = random_word();
    end
    return item;
  endfunction

  // Valid stays high after a transfer; the next call either replaces the payload
  // or drops valid for its gap.
  task automatic send_rotation(input qvr_in_t item);
    int unsigned gap;
    gap = sender_idle ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.mode   <= item.mode;
    in_ch.quat_w <= item.quat_w;
    in_ch.quat_x <= item.quat_x;
    in_ch.quat_y <= item.quat_y;
    in_ch.quat_z <= item.quat_z;
    in_ch.vec_x  <= item.vec_x;
    in_ch.vec_y  <= item.vec_y;
    in_ch.vec_z  <= item.vec_z;
    do @(posedge clk); while (!in_ch.ready);
    expected_rotations.push_back(rotate_vector(item));
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (expected_rotations.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    // Identity, then the extremes of the vector through the identity.
    send_rotation(make_item(MODE_ROTATE, 16384, 0, 0, 0, 1, 2, 3));
    send_rotation(make_item(MODE_INVERSE, 16384, 0, 0, 0, 32767, -32768, 0));
    // Half turn about z: negating -32768 must saturate.
    send_rotation(make_item(MODE_ROTATE, 0, 0, 0, 16384, -32768, 5, 7));
    send_rotation(make_item(MODE_INVERSE, 0, 0, 0, 16384, 32767, -32768, 32767));
    // Quarter turns about z in both directions, then about x and about y.
    send_rotation(make_item(MODE_ROTATE, 11585, 0, 0, 11585, 1000, 0, 0));
    send_rotation(make_item(MODE_INVERSE, 11585, 0, 0, 11585, 1000, 0, 0));
    send_rotation(make_item(MODE_ROTATE, 11585, 11585, 0, 0, 0, -2000, 300));
    send_rotation(make_item(MODE_INVERSE, 11585, 0, 11585, 0, 77, -2000, 300));
    // Exact halves: the diagonal term is one half, so ties round toward +infinity.
    send_rotation(make_item(MODE_ROTATE, 0, 0, 8192, 0, 1, 0, 0));
    send_rotation(make_item(MODE_ROTATE, 0, 0, 8192, 0, -1, 0, 0));
    send_rotation(make_item(MODE_INVERSE, 0, 0, 8192, 0, 3, 0, 0));
    send_rotation(make_item(MODE_ROTATE, 0, 0, 8192, 0, -3, 0, 0));
    // Zero quaternion keeps only the one-half diagonal.
    send_rotation(make_item(MODE_ROTATE, 0, 0, 0, 0, 32767, 32767, 32767));
    // Quaternions far from unit length, first at the extremes of every field.
    send_rotation(make_item(MODE_ROTATE, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_rotation(make_item(MODE_INVERSE, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_rotation(make_item(MODE_ROTATE, -32768, -32768, -32768, -32768,
                            -32768, -32768, -32768));
    send_rotation(make_item(MODE_INVERSE, -32768, -32768, -32768, -32768,
                            -32768, -32768, -32768));
    send_rotation(make_item(MODE_ROTATE, 32767, -32768, 32767, -32768,
                            -32768, 32767, -32768));
    send_rotation(make_item(MODE_INVERSE, -32768, 32767, -32768, 32767,
                            32767, -32768, 32767));
    send_rotation(make_item(MODE_ROTATE, 16384, 16384, 0, 0, 100, 200, 300));
    send_rotation(make_item(MODE_INVERSE, -1, 1, -1, 1, -1, 1, -1));
    wait_for_results();
  endtask

  // The receiver holds off while items keep coming, so the pipeline fills and stalls.
  task automatic test_output_stall();
    sender_idle      = 1'b0;
    sink_hold_cycles = 150;
    repeat (40) send_rotation(random_rotation());
    wait_for_results();
    sender_idle = 1'b1;
  endtask

  // Short bursts, each followed by a full drain.
  task automatic test_sender_pause();
    repeat (3) begin
      repeat (8) send_rotation(random_rotation());
      wait_for_results();
    end
  endtask

  task automatic test_random_stream(input int unsigned count);
    for (int i = 0; i < count; i++) begin
      // Idling changes every 50 items; some stretches run with no gaps at all.
      if (i % 50 == 0) begin
        sender_idle   = ($urandom_range(0, 2) != 0);
        receiver_idle = ($urandom_range(0, 2) != 0);
      end
      send_rotation(random_rotation());
    end
    wait_for_results();
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
  endtask

  initial begin : result_sink
    int unsigned stall;
    out_ch.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (sink_hold_cycles != 0) begin
        out_ch.ready <= 1'b0;
        repeat (sink_hold_cycles) @(posedge clk);
        sink_hold_cycles = 0;
      end
      stall = receiver_idle ? $urandom_range(0, 11) : 0;
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid && sink_hold_cycles == 0);
    end
  end

  always @(posedge clk) begin : check_results
    qvr_out_t got;
    qvr_out_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.out_x     = out_ch.out_x;
      got.out_y     = out_ch.out_y;
      got.out_z     = out_ch.out_z;
      got.saturated = out_ch.saturated;
      if (expected_rotations.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%t: unexpected result (%0d,%0d,%0d sat=%0b)", $realtime,
                   got.out_x, got.out_y, got.out_z, got.saturated);
        end
      end else begin
        want = expected_rotations.pop_front();
        if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
            got.out_z !== want.out_z || got.saturated !== want.saturated) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%t: rotation mismatch: expected (%0d,%0d,%0d sat=%0b) got (%0d,%0d,%0d sat=%0b)",
                     $realtime, want.out_x, want.out_y, want.out_z, want.saturated,
                     got.out_x, got.out_y, got.out_z, got.saturated);
          end
        end
      end
    end
  end

  initial begin : watchdog
    #5ms;
    $display("** quaternion_vector_rotate_top: FAILED **");
    $finish;
  end

  initial begin : run_tests
    in_ch.valid  <= 1'b0;
    in_ch.mode   <= MODE_ROTATE;
    in_ch.quat_w <= '0;
    in_ch.quat_x <= '0;
    in_ch.quat_y <= '0;
    in_ch.quat_z <= '0;
    in_ch.vec_x  <= '0;
    in_ch.vec_y  <= '0;
    in_ch.vec_z  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_output_stall();
    test_sender_pause();
    test_random_stream(920);
    wait_for_results();
    // Any extra result after the pipeline drains is flagged by check_results.
    repeat (12) @(posedge clk);
    if (mismatch_count == 0 && expected_rotations.size() == 0) begin
      $display("** quaternion_vector_rotate_top: PASSED **");
    end else begin
      $display("** quaternion_vector_rotate_top: FAILED **");
    end
    $finish;
  end

endmodule
